>>> src/gfcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfcd_pkg: shared constants and types of the gated frequency counter
// Holds default sizes, character codes and the control and status bundles
// that pass between the core and its decimal converter.
// ----------------------------------------------------------------------------
package gfcd_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int NUM_DIGITS_DEF = 10;

  localparam int GATE_W  = 10;
  localparam int POS_W   = 4;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 32;

  localparam logic [GATE_W-1:0] GATE_RESET = 10'd625;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic start;
    logic shift_digit;
  } conv_ctl_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] top_digit;
  } conv_sts_t;

endpackage
`default_nettype wire

>>> src/gfcd_bcd_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfcd_bcd_conv: bit-serial binary to BCD converter
// Shift-and-add-3 conversion, one binary bit per cycle. Afterwards the BCD
// word shifts out one digit per request, most significant digit first.
// ----------------------------------------------------------------------------
module gfcd_bcd_conv #(
  parameter int COUNT_BITS = gfcd_pkg::COUNT_BITS_DEF,
  parameter int NUM_DIGITS = gfcd_pkg::NUM_DIGITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  gfcd_pkg::conv_ctl_t      ctl,
  input  wire  [COUNT_BITS-1:0]    value,
  output gfcd_pkg::conv_sts_t      sts
);
  import gfcd_pkg::*;

  localparam int BCD_W = 4 * NUM_DIGITS;
  localparam int CNT_W = $clog2(COUNT_BITS + 1);
  localparam logic [BCD_W-1:0] NINES = {NUM_DIGITS{4'd9}};

  logic [COUNT_BITS-1:0] bin_sh;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      adj;
  logic [CNT_W-1:0]      bit_cnt;
  logic                  busy;
  logic                  ovf;
  logic                  ovf_next;

  // Digits of five or more get three added before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // A bit falling off the top digit means the value needs more digits.
  assign ovf_next = ovf | adj[BCD_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
    end else if (busy && bit_cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      bin_sh  <= value;
      bcd     <= '0;
      ovf     <= 1'b0;
      bit_cnt <= CNT_W'(COUNT_BITS);
    end else if (busy) begin
      bin_sh  <= bin_sh << 1;
      ovf     <= ovf_next;
      bit_cnt <= bit_cnt - CNT_W'(1);
      if (bit_cnt == CNT_W'(1) && ovf_next) begin
        bcd <= NINES;
      end else begin
        bcd <= {adj[BCD_W-2:0], bin_sh[COUNT_BITS-1]};
      end
    end else if (ctl.shift_digit) begin
      bcd <= bcd << 4;
    end
  end

  assign sts.busy      = busy;
  assign sts.top_digit = bcd[BCD_W-1 -: 4];

endmodule
`default_nettype wire

>>> src/gated_frequency_counter_decimal_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gated_frequency_counter_decimal_core: frequency meter with decimal readout
// Counts edge strobes over a gate of gate_ticks timebase ticks, captures
// the count when the gate closes and sends it out as right-aligned ASCII.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------------------
//  input    | in_valid, in_stall | edge_seen, tick_seen
//  output   | out_valid, out_stall | count_value, char_code, digit_position,
//           |                    | count_saturated, last_char
//  config   | cfg_we             | cfg_data (gate_ticks)
//
// An input beat is taken every cycle while the gate runs. The beat that
// closes the gate starts the decimal conversion: the bit-serial converter
// shifts the count in, then hands it over to the readout, and during all
// this in_stall is high. Then NUM_DIGITS character beats follow, one per
// cycle when out_stall is low; the input opens again as the last character
// enters the output register.
// Reset is synchronous; it sets gate_ticks to 625 and clears all counters.
// Output stalls hold the character beat and push back on the input.
// ----------------------------------------------------------------------------
module gated_frequency_counter_decimal_core #(
  parameter int COUNT_BITS = gfcd_pkg::COUNT_BITS_DEF,
  parameter int NUM_DIGITS = gfcd_pkg::NUM_DIGITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [gfcd_pkg::GATE_W-1:0]      cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              edge_seen,
  input  wire                              tick_seen,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [gfcd_pkg::COUNT_W-1:0]     count_value,
  output logic [gfcd_pkg::CHAR_W-1:0]      char_code,
  output logic [gfcd_pkg::POS_W-1:0]       digit_position,
  output logic                             count_saturated,
  output logic                             last_char
);
  import gfcd_pkg::*;

  localparam logic [1:0] ST_COUNT = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [POS_W-1:0]      LAST_POS  = POS_W'(NUM_DIGITS - 1);

  logic [1:0]            state;
  logic [GATE_W-1:0]     gate_ticks;
  logic [COUNT_BITS-1:0] edge_cnt;
  logic [COUNT_BITS-1:0] edge_cnt_next;
  logic [GATE_W-1:0]     tick_cnt;
  logic [GATE_W-1:0]     tick_cnt_next;
  logic                  sat;
  logic                  sat_next;
  logic                  in_accept;
  logic                  gate_close;
  logic [COUNT_BITS-1:0] snap_count;
  logic                  snap_sat;
  logic [POS_W-1:0]      emit_pos;
  logic                  leading;
  logic                  load_out;
  logic                  units;
  logic                  blank;
  conv_ctl_t             conv_ctl;
  conv_sts_t             conv_sts;

  // The user must write the gate register only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_ticks <= GATE_RESET;
    end else if (cfg_we) begin
      gate_ticks <= cfg_data;
    end
  end

  assign in_stall  = (state != ST_COUNT);
  assign in_accept = in_valid && !in_stall;

  // The edge in a beat belongs to the gate that the same beat may close.
  // The counter sticks at its maximum and raises the saturation flag.
  always_comb begin
    edge_cnt_next = edge_cnt;
    if (edge_seen && edge_cnt != COUNT_MAX) begin
      edge_cnt_next = edge_cnt + COUNT_BITS'(1);
    end
    sat_next      = sat | (edge_seen && edge_cnt_next == COUNT_MAX);
    tick_cnt_next = tick_cnt + GATE_W'(1);
    // A gate length at or below the ticks seen closes on this tick.
    gate_close    = tick_seen && !(tick_cnt_next < gate_ticks);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_cnt <= '0;
      tick_cnt <= '0;
      sat      <= 1'b0;
    end else if (in_accept) begin
      if (gate_close) begin
        edge_cnt <= '0;
        tick_cnt <= '0;
        sat      <= 1'b0;
      end else begin
        edge_cnt <= edge_cnt_next;
        sat      <= sat_next;
        if (tick_seen) begin
          tick_cnt <= tick_cnt_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && gate_close) begin
      snap_count <= edge_cnt_next;
      snap_sat   <= sat_next;
    end
  end

  // Character selection: a digit is blank while only zeros have been seen,
  // except the units digit, which always prints.
  assign load_out = !out_valid || !out_stall;
  assign units    = (emit_pos == LAST_POS);
  assign blank    = leading && (conv_sts.top_digit == 4'd0) && !units;

  assign conv_ctl.start       = in_accept && gate_close;
  assign conv_ctl.shift_digit = (state == ST_EMIT) && load_out;

  gfcd_bcd_conv #(
    .COUNT_BITS (COUNT_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_conv (
    .clk   (clk),
    .rst   (rst),
    .ctl   (conv_ctl),
    .value (edge_cnt_next),
    .sts   (conv_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COUNT;
      emit_pos <= '0;
      leading  <= 1'b1;
    end else begin
      case (state)
        ST_COUNT: begin
          if (in_accept && gate_close) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (!conv_sts.busy) begin
            state    <= ST_EMIT;
            emit_pos <= '0;
            leading  <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            leading  <= blank;
            emit_pos <= emit_pos + POS_W'(1);
            if (units) begin
              state <= ST_COUNT;
            end
          end
        end
        default: begin
          state <= ST_COUNT;
        end
      endcase
    end
  end

  // Output register: holds the current character beat under a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (conv_ctl.shift_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (conv_ctl.shift_digit) begin
      count_value     <= COUNT_W'(snap_count);
      char_code       <= blank ? CHAR_SPACE : CHAR_ZERO + CHAR_W'(conv_sts.top_digit);
      digit_position  <= emit_pos;
      count_saturated <= snap_sat;
      last_char       <= units;
    end
  end

endmodule
`default_nettype wire

>>> src/gfcd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfcd_checker: port-level checks of the frequency counter core
// Watches the character stream and the input back-pressure over time.
// ----------------------------------------------------------------------------
module gfcd_checker #(
  parameter int NUM_DIGITS = gfcd_pkg::NUM_DIGITS_DEF
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_stall,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [gfcd_pkg::CHAR_W-1:0]   char_code,
  input wire [gfcd_pkg::POS_W-1:0]    digit_position,
  input wire                          last_char
);
  import gfcd_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

  // The units flag and the last position go together.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_char == (digit_position == LAST_POS)))
    else $error("last_char does not match the units position");

  // Characters of one readout follow without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_char |=> out_valid)
    else $error("gap inside a readout");

  // No new input beat is taken while a readout is in flight.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_char |-> in_stall)
    else $error("input accepted during a readout");

  // Every character is a blank or a decimal digit.
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CHAR_SPACE ||
                   (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 8'd9)))
    else $error("character out of range");

  // A stalled character beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_code))
    else $error("stalled character changed");

endmodule

bind gated_frequency_counter_decimal_core gfcd_checker #(
  .NUM_DIGITS (NUM_DIGITS)
) u_gfcd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .char_code      (char_code),
  .digit_position (digit_position),
  .last_char      (last_char)
);
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the gated frequency counter core
// Feeds edge and tick samples through the valid/stall input channel and
// checks every character beat of each readout against an in-bench
// predictor of the counter and its right-aligned decimal conversion.
// ----------------------------------------------------------------------------
module testbench;

  import gfcd_pkg::*;

  localparam int COUNT_BITS     = COUNT_BITS_DEF;
  localparam int NUM_DIGITS     = NUM_DIGITS_DEF;
  // Covers one conversion and a readout of NUM_DIGITS beats, so this is
  // enough quiet time for the core to fall back to idle.
  localparam int SETTLE_CYCLES  = 48;
  // Longest stretch without any accepted beat in a correct run is the long
  // receiver hold plus one conversion and some random stalls.
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TIMEOUT_CYCLES = 4000;

  // One input sample and one expected character beat.
  typedef struct packed {
    logic edge_seen;
    logic tick_seen;
  } sample_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [CHAR_W-1:0]  ch;
    logic [POS_W-1:0]   pos;
    logic               sat;
    logic               last;
  } char_beat_t;

  // Clock, reset and all block inputs start at known values.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_we    = 1'b0;
  logic [GATE_W-1:0] cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              edge_seen = 1'b0;
  logic              tick_seen = 1'b0;
  logic              out_stall = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic [COUNT_W-1:0] count_value;
  logic [CHAR_W-1:0]  char_code;
  logic [POS_W-1:0]   digit_position;
  logic               count_saturated;
  logic               last_char;

  // Samples waiting to be driven and character beats waiting to arrive.
  sample_t    sample_q[$];
  char_beat_t char_expect_q[$];
  sample_t    next_sample;

  // Idle percentages of both sides; the stimulus process changes them
  // between phases, always on a falling edge.
  int tx_idle_pct = 23;
  int rx_idle_pct = 23;

  // A long receiver hold is requested by bumping hold_request.
  int hold_request = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  int mismatches   = 0;
  int quiet_cycles = 0;

  // Predictor state: its own copy of the gate, counters and saturation flag.
  logic [COUNT_BITS-1:0] gate_edges;
  logic [GATE_W-1:0]     gate_ticks_seen;
  logic [GATE_W-1:0]     gate_len;
  logic                  gate_sat;

  gated_frequency_counter_decimal_core uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .edge_seen      (edge_seen),
    .tick_seen      (tick_seen),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .count_value    (count_value),
    .char_code      (char_code),
    .digit_position (digit_position),
    .count_saturated(count_saturated),
    .last_char      (last_char)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Counts one sample into the predicted gate. When the tick closes the gate,
  // the count is captured, the gate restarts from zero and the ten character
  // beats of the readout are queued: blanks up to the first nonzero digit,
  // and the units digit is always shown so that zero reads as a lone '0'.
  task automatic predict_sample(input logic e, input logic t);
    char_beat_t      beat;
    longint unsigned rest;
    logic [3:0]      digit [0:NUM_DIGITS-1];
    logic            blank;
    begin
      // The edge counts first, so an edge that shares its sample with the
      // closing tick still belongs to the gate that closes.
      if (e) begin
        if (gate_edges != '1)
          gate_edges = gate_edges + 1'b1;
        if (gate_edges == '1)
          gate_sat = 1'b1;
      end
      if (t) begin
        gate_ticks_seen = gate_ticks_seen + 1'b1;
        // A gate length of zero, or one lowered below the ticks already
        // seen, closes the gate on this tick.
        if (gate_ticks_seen >= gate_len) begin
          beat.count = gate_edges;
          beat.sat   = gate_sat;
          rest       = gate_edges;
          gate_edges      = '0;
          gate_ticks_seen = '0;
          gate_sat        = 1'b0;
          for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
            digit[k] = 4'(rest % 10);
            rest     = rest / 10;
          end
          blank = 1'b1;
          for (int p = 0; p < NUM_DIGITS; p++) begin
            if (digit[p] != 4'd0 || p == NUM_DIGITS - 1)
              blank = 1'b0;
            beat.ch   = blank ? CHAR_SPACE : CHAR_ZERO + CHAR_W'(digit[p]);
            beat.pos  = POS_W'(p);
            beat.last = (p == NUM_DIGITS - 1);
            char_expect_q.push_back(beat);
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got, input int pos);
    begin
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch at position %0d: expected %0d, actual %0d",
                 $time, name, pos, want, got);
      end
    end
  endtask

  task automatic check_char_beat();
    char_beat_t want;
    begin
      if (char_expect_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected character beat: expected none, actual %0d at %0d",
                 $time, char_code, digit_position);
      end else begin
        want = char_expect_q.pop_front();
        check_field("count_value", want.count, count_value, int'(want.pos));
        check_field("char_code", 32'(want.ch), 32'(char_code), int'(want.pos));
        check_field("digit_position", 32'(want.pos), 32'(digit_position),
                    int'(want.pos));
        check_field("count_saturated", 32'(want.sat), 32'(count_saturated),
                    int'(want.pos));
        check_field("last_char", 32'(want.last), 32'(last_char), int'(want.pos));
      end
    end
  endtask

  // Driver: a new sample is offered only once the previous one was taken,
  // so a stalled beat keeps its valid and payload unchanged.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_sample = sample_q.pop_front();
        in_valid  <= 1'b1;
        edge_seen <= next_sample.edge_seen;
        tick_seen <= next_sample.tick_seen;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or one long hold when requested, which backs
  // the core up until it stalls its input while the driver keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      hold_left <= RX_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Monitor: follows register writes, predicts every accepted sample and
  // checks every accepted character beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      gate_edges      = '0;
      gate_ticks_seen = '0;
      gate_len        = GATE_RESET;
      gate_sat        = 1'b0;
    end else begin
      if (cfg_we)
        gate_len = cfg_data;
      if (in_valid && !in_stall)
        predict_sample(edge_seen, tick_seen);
      if (out_valid && !out_stall)
        check_char_beat();
    end
  end

  // Watchdog: ends the run if no beat of any kind is accepted for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= TIMEOUT_CYCLES) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic e, input logic t);
    sample_t s;
    begin
      s.edge_seen = e;
      s.tick_seen = t;
      sample_q.push_back(s);
    end
  endtask

  // Waits until every queued sample was taken and every readout arrived,
  // then lets the core settle so that it is idle for a register write.
  task automatic drain();
    begin
      while (sample_q.size() != 0 || in_valid || char_expect_q.size() != 0)
        @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
    end
  endtask

  task automatic write_gate(input int value);
    begin
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_data <= GATE_W'(value);
      @(posedge clk);
      cfg_we   <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic run_random(input int gate, input int count, input int tick_pct,
                            input int edge_pct);
    begin
      write_gate(gate);
      for (int i = 0; i < count; i++)
        push_sample($urandom_range(99) < edge_pct, $urandom_range(99) < tick_pct);
      drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The reset gate length of 625 ticks stays open over a short run of
    // ticking samples with random edges.
    for (int i = 0; i < 20; i++)
      push_sample($urandom_range(1) == 1, 1'b1);
    drain();

    // Directed part. Gate of one tick: the first tick closes the gate left
    // open above, then an edge that shares its sample with the closing tick,
    // and edges spread over a gate.
    write_gate(1);
    push_sample(1'b0, 1'b1);
    push_sample(1'b1, 1'b1);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b1);
    push_sample(1'b0, 1'b0);
    drain();

    // A zero gate length closes the gate on every tick.
    write_gate(0);
    push_sample(1'b1, 1'b1);
    push_sample(1'b0, 1'b1);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b1);
    drain();

    // Two ticks into a gate of four, then the gate is cut to one: the next
    // tick must close it with all edges seen so far.
    write_gate(4);
    push_sample(1'b1, 1'b1);
    push_sample(1'b1, 1'b1);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b0);
    drain();
    write_gate(1);
    push_sample(1'b1, 1'b1);
    drain();

    // Random phases over several gate lengths.
    run_random(2, 35, 50, 50);

    // A long stretch with no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(1, 45, 70, 60);
    tx_idle_pct = 23;
    rx_idle_pct = 23;

    // The receiver holds off while samples keep coming, so the core fills
    // up and pushes back on its input.
    hold_request++;
    run_random(3, 40, 80, 30);

    run_random(5, 25, 90, 80);
    run_random($urandom_range(12, 1), 20, $urandom_range(90, 20), $urandom_range(99));
    run_random(1, 15, 40, 90);

    // Nothing is outstanding here; a late or extra beat would still be
    // caught by the monitor during the settle time of the last drain.
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && char_expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
